[design/bil_pkg.sv]
// Package with shared constants and helper functions for the binomial IIR lowpass filter.
package bil_pkg;

  localparam int unsigned CoefW   = 32;
  localparam int unsigned GainW   = 32;
  localparam int unsigned OrderW  = 2;
  localparam int unsigned FracW   = 28;
  localparam int unsigned SplitW  = 32;
  localparam int unsigned HiShift = SplitW - FracW;
  localparam int unsigned MulW    = 33;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned QloW    = ProdW - FracW;
  localparam int unsigned TermW   = 63;
  localparam int unsigned SumW    = 65;
  localparam int unsigned WideW   = 64;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 3;

  localparam int unsigned TermLimExp = 61;
  localparam int unsigned TermThrExp = 58;

  localparam logic [RegIdxW-1:0] RegOrder = 3'd0;
  localparam logic [RegIdxW-1:0] RegCoefA = 3'd1;
  localparam logic [RegIdxW-1:0] RegCoefB = 3'd2;
  localparam logic [RegIdxW-1:0] RegCoefC = 3'd3;
  localparam logic [RegIdxW-1:0] RegGain  = 3'd4;

  localparam logic [OrderW-1:0] CoefSelA = 2'd0;
  localparam logic [OrderW-1:0] CoefSelB = 2'd1;
  localparam logic [OrderW-1:0] CoefSelC = 2'd2;

  typedef logic signed [CoefW-1:0] coef_t;

  // Binomial numerator weight of tap k for the given order (1 1, 1 2 1, 1 3 3 1).
  function automatic logic [1:0] binom_weight(input logic [OrderW-1:0] order,
                                              input logic [1:0] tap);
    logic [1:0] w;
    w = 2'd0;
    case (order)
      2'd1: begin
        if (tap == 2'd0 || tap == 2'd1) w = 2'd1;
      end
      2'd2: begin
        if (tap == 2'd1) w = 2'd2;
        else if (tap == 2'd0 || tap == 2'd2) w = 2'd1;
      end
      2'd3: begin
        if (tap == 2'd0 || tap == 2'd3) w = 2'd1;
        else w = 2'd3;
      end
      default: w = 2'd0;
    endcase
    return w;
  endfunction

endpackage

[design/binomial_iir_lowpass.sv]
// Top level of the binomial IIR lowpass filter with its sequencer and shared multiplier.
// Streaming IIR lowpass of order one to three with a fixed binomial numerator and
// configurable Q4.28 feedback weights; each input transaction yields one output
// transaction, the unscaled output times the Q0.32 inverse DC gain, saturated to the
// sample width. All products go through a single registered 33 by 33 bit multiplier:
// each feedback term passes low half, high half, rounding and clamp, and accumulate
// steps, and the gain scaling a low half, a high half and a final add and saturate step that
// waits while the output register is still full. The finished result sits in an output
// register, so the next sample can be taken while it waits. Configuration must be
// written over the APB port only while the block is idle; the block does not enforce
// this. An order of zero acts as order one and an order above MAX_ORDER as MAX_ORDER.
module binomial_iir_lowpass
  import bil_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned ACC_WIDTH    = 48,
  parameter int unsigned MAX_ORDER    = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [AddrW-1:0]               paddr,
  input  logic [DataW-1:0]               pwdata,
  output logic [DataW-1:0]               prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_out_o
);

  localparam int unsigned IdxW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  localparam logic signed [SumW-1:0] AccMax = (SumW'(1) <<< (ACC_WIDTH - 1)) - SumW'(1);
  localparam logic signed [SumW-1:0] AccMin = -AccMax - SumW'(1);
  localparam logic signed [ProdW-1:0] SmpMax =
    (ProdW'(1) <<< (SAMPLE_WIDTH - 1)) - ProdW'(1);
  localparam logic signed [ProdW-1:0] SmpMin = -SmpMax - ProdW'(1);
  localparam logic signed [ProdW-1:0] TermLim = ProdW'(1) <<< TermLimExp;
  localparam logic signed [ProdW-1:0] TermThr = ProdW'(1) <<< TermThrExp;
  localparam logic signed [ProdW-1:0] RndLo   = ProdW'(1) <<< (FracW - 1);
  localparam logic signed [ProdW-1:0] RndOut  = ProdW'(1) <<< (SplitW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_TERM,
    S_SUM,
    S_OLO,
    S_OHI,
    S_OFIN
  } state_e;

  state_e                          state_q;
  logic [OrderW-1:0]               order_q;
  logic [IdxW-1:0]                 tcnt_q;
  logic [OrderW-1:0]               cfg_order_q;
  coef_t                           coef_a_q;
  coef_t                           coef_b_q;
  coef_t                           coef_c_q;
  logic [GainW-1:0]                gain_q;
  logic signed [SAMPLE_WIDTH-1:0]  in_hist_q  [MAX_ORDER];
  logic signed [ACC_WIDTH-1:0]     out_hist_q [MAX_ORDER];
  logic signed [SAMPLE_WIDTH-1:0]  x_q;
  logic signed [SumW-1:0]          acc_q;
  logic signed [ProdW-1:0]         prod_q;
  logic signed [QloW-1:0]          qlo_q;
  logic signed [TermW-1:0]         term_q;
  logic [SplitW-1:0]               tlo_q;
  logic                            out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0]  out_data_q;

  logic                            cfg_wr;
  logic [RegIdxW-1:0]              reg_idx;
  logic                            accept_in;
  logic [OrderW-1:0]               order_eff;
  logic signed [SumW-1:0]          bsum;
  logic signed [ACC_WIDTH-1:0]     y_sel;
  logic signed [WideW-1:0]         y_ext;
  logic signed [WideW-1:0]         acc_ext;
  logic [OrderW-1:0]               coef_idx;
  coef_t                           coef_sel;
  logic signed [MulW-1:0]          mul_a;
  logic signed [MulW-1:0]          mul_b;
  logic signed [ProdW-1:0]         mul_p;
  logic signed [ProdW-1:0]         lo_rnd;
  logic signed [QloW-1:0]          qlo_d;
  logic signed [ProdW-1:0]         term_raw;
  logic signed [TermW-1:0]         term_d;
  logic signed [SumW-1:0]          sum_d;
  logic signed [SumW-1:0]          acc_sat;
  logic                            term_last;
  logic signed [ProdW-1:0]         out_rnd;
  logic [SplitW-1:0]               tlo_d;
  logic signed [ProdW-1:0]         out_raw;
  logic signed [SAMPLE_WIDTH-1:0]  out_d;

  assign cfg_wr     = psel & penable & pwrite;
  assign reg_idx    = paddr[AddrW-1:2];
  assign pready     = 1'b1;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept_in  = in_valid_i & in_ready_o;

  assign out_valid_o    = out_valid_q;
  assign filtered_out_o = out_data_q;

  always_comb begin
    case (reg_idx)
      RegOrder: prdata = DataW'(cfg_order_q);
      RegCoefA: prdata = coef_a_q;
      RegCoefB: prdata = coef_b_q;
      RegCoefC: prdata = coef_c_q;
      RegGain:  prdata = gain_q;
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    order_eff = cfg_order_q;
    if (cfg_order_q == 2'd0) begin
      order_eff = 2'd1;
    end else if (cfg_order_q > OrderW'(MAX_ORDER)) begin
      order_eff = OrderW'(MAX_ORDER);
    end
  end

  // Binomial numerator over the new sample and the stored input history.
  always_comb begin
    logic signed [SAMPLE_WIDTH-1:0] tap;
    logic [1:0]                     w;
    bsum = '0;
    for (int k = 0; k <= 3; k++) begin
      tap = '0;
      if (k == 0) begin
        tap = sample_in_i;
      end else if (k <= MAX_ORDER) begin
        tap = in_hist_q[k-1];
      end
      w = binom_weight(order_eff, 2'(k));
      if (w[0]) bsum = bsum + SumW'(tap);
      if (w[1]) bsum = bsum + (SumW'(tap) <<< 1);
    end
  end

  assign y_sel     = out_hist_q[tcnt_q];
  assign y_ext     = WideW'(y_sel);
  assign acc_ext   = acc_q[WideW-1:0];
  assign coef_idx  = order_q - 2'd1 - 2'(tcnt_q);
  assign term_last = (2'(tcnt_q) == order_q - 2'd1);

  always_comb begin
    case (coef_idx)
      CoefSelA: coef_sel = coef_a_q;
      CoefSelB: coef_sel = coef_b_q;
      CoefSelC: coef_sel = coef_c_q;
      default:  coef_sel = coef_a_q;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_LO: begin
        mul_a = MulW'(coef_sel);
        mul_b = {1'b0, y_ext[SplitW-1:0]};
      end
      S_HI: begin
        mul_a = MulW'(coef_sel);
        mul_b = MulW'(signed'(y_ext[WideW-1:SplitW]));
      end
      S_OLO: begin
        mul_a = {1'b0, gain_q};
        mul_b = {1'b0, acc_ext[SplitW-1:0]};
      end
      S_OHI: begin
        mul_a = {1'b0, gain_q};
        mul_b = MulW'(signed'(acc_ext[WideW-1:SplitW]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign lo_rnd = prod_q + RndLo;
  assign qlo_d  = lo_rnd[ProdW-1:FracW];

  assign term_raw = (prod_q <<< HiShift) + ProdW'(qlo_q);

  always_comb begin
    if (prod_q > TermThr) begin
      term_d = TermW'(TermLim);
    end else if (prod_q < -TermThr) begin
      term_d = TermW'(-TermLim);
    end else if (term_raw > TermLim) begin
      term_d = TermW'(TermLim);
    end else if (term_raw < -TermLim) begin
      term_d = TermW'(-TermLim);
    end else begin
      term_d = TermW'(term_raw);
    end
  end

  assign sum_d = acc_q + SumW'(term_q);

  always_comb begin
    if (sum_d > AccMax) begin
      acc_sat = AccMax;
    end else if (sum_d < AccMin) begin
      acc_sat = AccMin;
    end else begin
      acc_sat = sum_d;
    end
  end

  assign out_rnd = prod_q + RndOut;
  assign tlo_d   = out_rnd[WideW-1:SplitW];
  assign out_raw = prod_q + ProdW'({1'b0, tlo_q});

  always_comb begin
    if (out_raw > SmpMax) begin
      out_d = SAMPLE_WIDTH'(SmpMax);
    end else if (out_raw < SmpMin) begin
      out_d = SAMPLE_WIDTH'(SmpMin);
    end else begin
      out_d = SAMPLE_WIDTH'(out_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      order_q     <= 2'd1;
      tcnt_q      <= '0;
      cfg_order_q <= 2'd1;
      coef_a_q    <= '0;
      coef_b_q    <= '0;
      coef_c_q    <= '0;
      gain_q      <= '0;
      in_hist_q   <= '{default: '0};
      out_hist_q  <= '{default: '0};
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          RegOrder: cfg_order_q <= pwdata[OrderW-1:0];
          RegCoefA: coef_a_q    <= pwdata;
          RegCoefB: coef_b_q    <= pwdata;
          RegCoefC: coef_c_q    <= pwdata;
          RegGain:  gain_q      <= pwdata;
          default:  ;
        endcase
      end
      if (out_valid_q && out_ready_i && (state_q != S_OFIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept_in) begin
            acc_q   <= bsum;
            order_q <= order_eff;
            tcnt_q  <= '0;
            state_q <= S_LO;
          end
        end
        S_LO:   state_q <= S_HI;
        S_HI:   state_q <= S_TERM;
        S_TERM: state_q <= S_SUM;
        S_SUM: begin
          if (term_last) begin
            acc_q         <= acc_sat;
            in_hist_q[0]  <= x_q;
            out_hist_q[0] <= acc_sat[ACC_WIDTH-1:0];
            for (int k = 1; k < MAX_ORDER; k++) begin
              in_hist_q[k]  <= in_hist_q[k-1];
              out_hist_q[k] <= out_hist_q[k-1];
            end
            state_q <= S_OLO;
          end else begin
            acc_q   <= sum_d;
            tcnt_q  <= tcnt_q + IdxW'(1);
            state_q <= S_LO;
          end
        end
        S_OLO: state_q <= S_OHI;
        S_OHI: state_q <= S_OFIN;
        S_OFIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= out_d;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q != S_OFIN) begin
      prod_q <= mul_p;
    end
    if (accept_in) begin
      x_q <= sample_in_i;
    end
    if (state_q == S_HI) begin
      qlo_q <= qlo_d;
    end
    if (state_q == S_TERM) begin
      term_q <= term_d;
    end
    if (state_q == S_OHI) begin
      tlo_q <= tlo_d;
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> (state_q == S_LO))
    else $error("Accepted transaction did not start the multiply sequence.");

  a_result_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OFIN))
    else $error("Output became valid outside the final step.");

  a_order_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (order_q != 2'd0 && order_q <= OrderW'(MAX_ORDER)))
    else $error("Latched order is out of range while busy.");

  a_term_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (2'(tcnt_q) < order_q))
    else $error("Feedback term counter ran past the order.");
`endif

endmodule

[test/binomial_iir_lowpass_test.sv]
// Self-checking testbench for the binomial IIR lowpass filter with its own predictor.
module binomial_iir_lowpass_test;
  import bil_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SampleW     = 16;
  localparam int ClkPeriod   = 10;
  localparam int SettleTicks = 24;
  localparam int StallTicks  = 300;
  localparam int CycleLimit  = 400000;
  localparam int PhaseItems  = 54;
  localparam int PlanRows    = 33;

  localparam logic [RegIdxW-1:0] RegUnusedLo = 3'd5;
  localparam logic [RegIdxW-1:0] RegUnusedHi = 3'd7;

  typedef logic signed [95:0] wide_t;
  typedef logic signed [SampleW-1:0] sample_t;

  localparam wide_t AccMax    = (wide_t'(1) <<< 47) - 1;
  localparam wide_t AccMin    = -AccMax - 1;
  localparam wide_t TermLim   = wide_t'(1) <<< TermLimExp;
  localparam wide_t CoefHalf  = wide_t'(1) <<< (FracW - 1);
  localparam wide_t GainHalf  = wide_t'(1) <<< 31;
  localparam wide_t SampleMax = 32767;
  localparam wide_t SampleMin = -32768;

  typedef enum logic {RowSample, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [RegIdxW-1:0]  reg_idx;
    logic [DataW-1:0]    wdata;
    sample_t             sample;
    logic                checked;
    sample_t             result;
  } plan_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [DataW-1:0]   pwdata = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  sample_t            sample_in_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  sample_t            filtered_out_o;

  logic [1:0]         cfg_order = 2'd1;
  logic signed [31:0] cfg_coef_a = '0;
  logic signed [31:0] cfg_coef_b = '0;
  logic signed [31:0] cfg_coef_c = '0;
  logic [31:0]        cfg_gain = '0;
  sample_t            x_hist [3] = '{default: '0};
  logic signed [47:0] y_hist [3] = '{default: '0};

  sample_t            pending_outputs [$];
  int                 fault_count = 0;
  int                 cycle_count = 0;
  int                 tx_idle_pct = 24;
  int                 rx_idle_pct = 24;
  int                 stall_left = 0;
  bit                 stall_req = 1'b0;

  binomial_iir_lowpass dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_in_i   (sample_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .filtered_out_o(filtered_out_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic void log_fault(input string what, input longint want, input longint got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  function automatic wide_t feedback_term(input logic signed [31:0] coef,
                                          input logic signed [47:0] y);
    wide_t t;
    t = ((wide_t'(coef) * wide_t'(y)) + CoefHalf) >>> FracW;
    if (t > TermLim) t = TermLim;
    if (t < -TermLim) t = -TermLim;
    return t;
  endfunction

  function automatic sample_t lowpass_step(input sample_t x);
    wide_t acc;
    wide_t g;
    wide_t scaled;
    g = {64'd0, cfg_gain};
    case (cfg_order)
      2'd0, 2'd1: begin
        acc = wide_t'(x) + wide_t'(x_hist[0]) + feedback_term(cfg_coef_a, y_hist[0]);
      end
      2'd2: begin
        acc = wide_t'(x) + 2 * wide_t'(x_hist[0]) + wide_t'(x_hist[1])
            + feedback_term(cfg_coef_a, y_hist[1]) + feedback_term(cfg_coef_b, y_hist[0]);
      end
      default: begin
        acc = wide_t'(x) + 3 * (wide_t'(x_hist[0]) + wide_t'(x_hist[1])) + wide_t'(x_hist[2])
            + feedback_term(cfg_coef_a, y_hist[2]) + feedback_term(cfg_coef_b, y_hist[1])
            + feedback_term(cfg_coef_c, y_hist[0]);
      end
    endcase
    if (acc > AccMax) acc = AccMax;
    if (acc < AccMin) acc = AccMin;
    x_hist[2] = x_hist[1];
    x_hist[1] = x_hist[0];
    x_hist[0] = x;
    y_hist[2] = y_hist[1];
    y_hist[1] = y_hist[0];
    y_hist[0] = acc[47:0];
    scaled = (acc * g + GainHalf) >>> 32;
    if (scaled > SampleMax) scaled = SampleMax;
    if (scaled < SampleMin) scaled = SampleMin;
    return scaled[SampleW-1:0];
  endfunction

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] value);
    logic [DataW-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegOrder: cfg_order = value[1:0];
      RegCoefA: cfg_coef_a = value;
      RegCoefB: cfg_coef_b = value;
      RegCoefC: cfg_coef_c = value;
      RegGain:  cfg_gain = value;
      default: ;
    endcase
    if (idx <= RegGain) begin
      want = (idx == RegOrder) ? {30'd0, value[1:0]} : value;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata !== want) log_fault("register read", want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic offer_sample(input sample_t s, input logic checked, input sample_t result);
    sample_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = lowpass_step(s);
    pending_outputs.push_back(checked ? result : predicted);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outputs.size() == 0) begin
        log_fault("unexpected output", 0, filtered_out_o);
      end else if (filtered_out_o !== pending_outputs[0]) begin
        log_fault("output", pending_outputs.pop_front(), filtered_out_o);
      end else begin
        void'(pending_outputs.pop_front());
      end
    end
    if (stall_req) begin
      stall_left = StallTicks;
      stall_req = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("[binomial_iir_lowpass] ERROR");
      $finish;
    end
  end

  initial begin
    plan_row_t          directed_plan [PlanRows];
    sample_t            s;
    sample_t            last_sample;
    logic signed [31:0] jit;

    directed_plan = '{
      '{RowSample, RegOrder,    32'd0,          16'sh7FFF,   1'b1, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sh8000,   1'b1, 16'sd0},
      '{RowWrite,  RegGain,     32'hFFFF_FFFF,  16'sd0,      1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sh7FFF,   1'b1, -16'sd1},
      '{RowSample, RegOrder,    32'd0,          16'sh7FFF,   1'b1, 16'sh7FFF},
      '{RowSample, RegOrder,    32'd0,          16'sh8000,   1'b1, -16'sd1},
      '{RowSample, RegOrder,    32'd0,          16'sh8000,   1'b1, 16'sh8000},
      '{RowWrite,  RegOrder,    32'd0,          16'sd0,      1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sd0,      1'b1, 16'sh8000},
      '{RowSample, RegOrder,    32'd0,          16'sd1,      1'b1, 16'sd1},
      '{RowWrite,  RegCoefA,    32'h7FFF_FFFF,  16'sd0,      1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sh7FFF,   1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sh7FFF,   1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sh7FFF,   1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          -16'sd1,     1'b0, 16'sd0},
      '{RowWrite,  RegCoefA,    32'h8000_0000,  16'sd0,      1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sh8000,   1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sh7FFF,   1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sd0,      1'b0, 16'sd0},
      '{RowWrite,  RegCoefB,    32'h7FFF_FFFF,  16'sd0,      1'b0, 16'sd0},
      '{RowWrite,  RegCoefC,    32'h8000_0000,  16'sd0,      1'b0, 16'sd0},
      '{RowWrite,  RegOrder,    32'd3,          16'sd0,      1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sd12345,  1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sh8000,   1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sd0,      1'b0, 16'sd0},
      '{RowWrite,  RegOrder,    32'd2,          16'sd0,      1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sh7FFF,   1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          -16'sd2,     1'b0, 16'sd0},
      '{RowWrite,  RegUnusedLo, 32'hFFFF_FFFF,  16'sd0,      1'b0, 16'sd0},
      '{RowWrite,  RegUnusedHi, 32'h1234_5678,  16'sd0,      1'b0, 16'sd0},
      '{RowWrite,  RegGain,     32'd0,          16'sd0,      1'b0, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          16'sd21845,  1'b1, 16'sd0},
      '{RowSample, RegOrder,    32'd0,          -16'sd21846, 1'b1, 16'sd0}
    };
    last_sample = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PlanRows; i++) begin
      if (directed_plan[i].kind == RowWrite) begin
        settle();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].wdata);
      end else begin
        offer_sample(directed_plan[i].sample, directed_plan[i].checked,
                     directed_plan[i].result);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      jit = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      if (ph == 7) begin
        write_reg(RegOrder, 32'd3);
        write_reg(RegCoefA, 32'h7FFF_FFFF);
        write_reg(RegCoefB, 32'h8000_0000);
        write_reg(RegCoefC, 32'h7FFF_FFFF);
        write_reg(RegGain, 32'hFFFF_FFFF);
      end else begin
        case (ph % 4)
          0: begin
            write_reg(RegOrder, 32'd1);
            write_reg(RegCoefA, 32'h0800_0000 + jit);
            write_reg(RegCoefB, $urandom());
            write_reg(RegCoefC, $urandom());
            write_reg(RegGain, 32'h4000_0000);
          end
          1: begin
            write_reg(RegOrder, 32'd2);
            write_reg(RegCoefA, -32'sd107374182 + jit);
            write_reg(RegCoefB, 32'sd295279002 - jit);
            write_reg(RegCoefC, $urandom());
            write_reg(RegGain, 32'd322122547);
          end
          2: begin
            write_reg(RegOrder, 32'd3);
            write_reg(RegCoefA, 32'sd40265318 + jit);
            write_reg(RegCoefB, -32'sd187904819);
            write_reg(RegCoefC, 32'sd375809638 - jit);
            write_reg(RegGain, 32'd80530636);
          end
          default: begin
            write_reg(RegOrder, $urandom_range(0, 3));
            write_reg(RegCoefA, $urandom());
            write_reg(RegCoefB, $urandom());
            write_reg(RegCoefC, $urandom());
            write_reg(RegGain, $urandom());
          end
        endcase
      end
      tx_idle_pct = (ph == 2) ? 0 : 24;
      rx_idle_pct = (ph == 2) ? 0 : 24;
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 4 && n == 20) stall_req = 1'b1;
        if (ph == 5 && n == 27) settle();
        case ($urandom_range(0, 9))
          0:       s = 16'sh7FFF;
          1:       s = 16'sh8000;
          2, 3:    s = sample_t'($urandom_range(0, 2000)) - 16'sd1000;
          4:       s = last_sample;
          default: s = sample_t'($urandom());
        endcase
        last_sample = s;
        offer_sample(s, 1'b0, '0);
      end
    end

    settle();
    if (fault_count == 0 && pending_outputs.size() == 0) begin
      $display("[binomial_iir_lowpass] OK");
    end else begin
      $display("[binomial_iir_lowpass] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/bil_pkg.sv
design/binomial_iir_lowpass.sv
test/binomial_iir_lowpass_test.sv
